### design/block_transfer_address_sequencer_macros.svh
// Assertion macros for the block transfer address sequencer.
// Used by files that check the block; needs clk and rst in scope.
`ifndef BLOCK_TRANSFER_ADDRESS_SEQUENCER_MACROS_SVH
`define BLOCK_TRANSFER_ADDRESS_SEQUENCER_MACROS_SVH

// same-cycle implication
`define BTAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btas check failed");

// next-cycle implication
`define BTAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btas check failed");

`endif

### design/btas_pkg.sv
// Shared types, constants and a function for the block transfer address sequencer.
// No dependencies.
`timescale 1ns / 1ps

package btas_pkg;

  localparam int unsigned AddrWidth = 32;
  localparam int unsigned ListWidth = 16;
  localparam int unsigned RegWidth  = 4;
  localparam int unsigned CntWidth  = 5;
  localparam int unsigned SpanWidth = CntWidth + 2;

  localparam logic [AddrWidth-1:0] WORD_STEP  = 32'h0000_0004;
  localparam logic [ListWidth-1:0] EMPTY_LIST = 16'h8000;
  localparam logic [RegWidth-1:0]  PC_REG     = 4'd15;
  localparam logic [CntWidth-1:0]  EMPTY_CNT  = 5'd16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BASE,
    S_FIRST,
    S_EMIT
  } seq_state_t;

  typedef enum logic [2:0] {
    AOP_HOLD,
    AOP_LOAD,
    AOP_NEWBASE,
    AOP_FIRST,
    AOP_STEP
  } addr_op_t;

  typedef enum logic [1:0] {
    SRC_REG   = 2'd0,
    SRC_PLUS4 = 2'd1,
    SRC_BASE  = 2'd2
  } store_src_t;

  typedef struct packed {
    logic [RegWidth-1:0] reg_number;
    logic                load_transfer;
    logic                use_user_regs;
    store_src_t          store_source;
    logic                base_update;
    logic                flush_fetch;
    logic                last_transfer;
  } emit_t;

  function automatic logic [CntWidth-1:0] popcount16(input logic [ListWidth-1:0] x);
    logic [2:0] nib [4];
    logic [CntWidth-1:0] total;
    for (int i = 0; i < 4; i++) begin
      nib[i] = 3'(x[4*i]) + 3'(x[4*i+1]) + 3'(x[4*i+2]) + 3'(x[4*i+3]);
    end
    total = CntWidth'(nib[0]) + CntWidth'(nib[1]) + CntWidth'(nib[2]) + CntWidth'(nib[3]);
    return total;
  endfunction

endpackage

### design/btas_addr_unit.sv
// Address unit: base, updated base and transfer address registers around one adder.
// Depends on btas_pkg.
`timescale 1ns / 1ps

module btas_addr_unit (
  input  logic                               clk,
  input  btas_pkg::addr_op_t                 aop,
  input  logic [btas_pkg::AddrWidth-1:0]     base_value,
  input  logic [btas_pkg::ListWidth-1:0]     register_list,
  input  logic                               pre_index,
  input  logic                               count_up,
  output logic [btas_pkg::AddrWidth-1:0]     newbase,
  output logic [btas_pkg::AddrWidth-1:0]     addr
);

  logic [btas_pkg::AddrWidth-1:0] base;
  logic [btas_pkg::SpanWidth-1:0] span;
  logic                           up;
  logic                           pre;

  logic [btas_pkg::AddrWidth-1:0] opa;
  logic [btas_pkg::AddrWidth-1:0] opb;
  logic                           cin;
  logic [btas_pkg::AddrWidth-1:0] sum;
  logic [btas_pkg::AddrWidth-1:0] span_ext;
  logic [btas_pkg::CntWidth-1:0]  cnt_in;

  assign span_ext = {{(btas_pkg::AddrWidth - btas_pkg::SpanWidth){1'b0}}, span};
  assign cnt_in   = (register_list == '0) ? btas_pkg::EMPTY_CNT
                                          : btas_pkg::popcount16(register_list);

  // operand select for the shared adder
  always_comb begin
    opa = addr;
    opb = btas_pkg::WORD_STEP;
    cin = 1'b0;
    unique case (aop)
      btas_pkg::AOP_NEWBASE: begin
        opa = base;
        opb = up ? span_ext : ~span_ext;
        cin = ~up;
      end
      btas_pkg::AOP_FIRST: begin
        opa = up ? base : newbase;
        opb = pre ? btas_pkg::WORD_STEP : '0;
      end
      default: begin
        opa = addr;
        opb = btas_pkg::WORD_STEP;
      end
    endcase
  end

  assign sum = opa + opb + {{(btas_pkg::AddrWidth-1){1'b0}}, cin};

  always_ff @(posedge clk) begin
    unique case (aop)
      btas_pkg::AOP_LOAD: begin
        base <= base_value;
        span <= {cnt_in, 2'b00};
        up   <= count_up;
        pre  <= count_up ? pre_index : ~pre_index;
      end
      btas_pkg::AOP_NEWBASE: newbase <= sum;
      btas_pkg::AOP_FIRST:   addr    <= sum;
      btas_pkg::AOP_STEP:    addr    <= sum;
      default: ;
    endcase
  end

endmodule

### design/btas_seq.sv
// Sequencer: takes an item, walks the register list lowest first, builds each result's flags.
// Depends on btas_pkg.
`timescale 1ns / 1ps

module btas_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [btas_pkg::RegWidth-1:0]  base_index,
  input  logic [btas_pkg::ListWidth-1:0] register_list,
  input  logic                           user_bank_request,
  input  logic                           write_back,
  input  logic                           is_load_op,
  input  logic                           out_valid,
  input  logic                           out_stall,
  output btas_pkg::addr_op_t             aop,
  output logic                           emit_load,
  output btas_pkg::emit_t                emit
);

  btas_pkg::seq_state_t state, state_next;

  logic [btas_pkg::ListWidth-1:0] rem, rem_next;
  logic [btas_pkg::RegWidth-1:0]  bidx;
  logic                           load_op;
  logic                           usr;
  logic                           upd;
  logic                           first, first_next;

  logic [btas_pkg::RegWidth-1:0]  idx;
  logic [btas_pkg::ListWidth-1:0] rem_clr;
  logic                           is_last;
  logic                           accept;

  assign accept = in_valid && (state == btas_pkg::S_IDLE);

  // lowest set bit
  always_comb begin
    idx = '0;
    for (int i = btas_pkg::ListWidth - 1; i >= 0; i--) begin
      if (rem[i]) idx = btas_pkg::RegWidth'(i);
    end
  end

  assign rem_clr = rem & ~(btas_pkg::ListWidth'(1) << idx);
  assign is_last = (rem_clr == '0);

  always_comb begin
    state_next = state;
    rem_next   = rem;
    first_next = first;
    in_stall   = 1'b1;
    aop        = btas_pkg::AOP_HOLD;
    emit_load  = 1'b0;

    emit.reg_number    = idx;
    emit.load_transfer = load_op;
    emit.use_user_regs = usr;
    emit.store_source  = btas_pkg::SRC_REG;
    if (!load_op) begin
      if (idx == bidx && !first) emit.store_source = btas_pkg::SRC_BASE;
      else if (idx == btas_pkg::PC_REG) emit.store_source = btas_pkg::SRC_PLUS4;
    end
    emit.base_update   = is_last && upd;
    emit.flush_fetch   = load_op && (idx == btas_pkg::PC_REG);
    emit.last_transfer = is_last;

    unique case (state)
      btas_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          aop        = btas_pkg::AOP_LOAD;
          rem_next   = (register_list == '0) ? btas_pkg::EMPTY_LIST : register_list;
          first_next = 1'b1;
          state_next = btas_pkg::S_BASE;
        end
      end
      btas_pkg::S_BASE: begin
        aop        = btas_pkg::AOP_NEWBASE;
        state_next = btas_pkg::S_FIRST;
      end
      btas_pkg::S_FIRST: begin
        aop        = btas_pkg::AOP_FIRST;
        state_next = btas_pkg::S_EMIT;
      end
      btas_pkg::S_EMIT: begin
        if (!out_valid || !out_stall) begin
          aop        = btas_pkg::AOP_STEP;
          emit_load  = 1'b1;
          rem_next   = rem_clr;
          first_next = 1'b0;
          if (is_last) state_next = btas_pkg::S_IDLE;
        end
      end
      default: state_next = btas_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btas_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rem   <= rem_next;
    first <= first_next;
    if (accept) begin
      bidx    <= base_index;
      load_op <= is_load_op;
      usr     <= user_bank_request && !register_list[btas_pkg::ListWidth-1];
      upd     <= (register_list == '0) ||
                 (write_back && (!is_load_op || !register_list[base_index]));
    end
  end

endmodule

### design/block_transfer_address_sequencer.sv
// Top level of the block transfer address sequencer: sequencer, address unit, output register.
// Depends on btas_pkg, btas_seq, btas_addr_unit and the assertion macro header.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_stall  | base_value base_index register_list P U S W L
//  out     | out_valid/out_stall| reg_number word_address flags updated_base
//
// An item with n listed registers (n = 1 for an empty list) gives n results: it is accepted,
// the shared 32-bit adder forms the updated base, then the first address, then one result per
// cycle while the output is not stalled, each stepping the address on the same adder. An
// output stall holds the sequencer in place; the next item is taken after the last result.
// Reset is synchronous and clears the sequencer state and the output valid flag.
`timescale 1ns / 1ps

`include "block_transfer_address_sequencer_macros.svh"

module block_transfer_address_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] base_value,
  input  logic [3:0]  base_index,
  input  logic [15:0] register_list,
  input  logic        pre_index,
  input  logic        count_up,
  input  logic        user_bank_request,
  input  logic        write_back,
  input  logic        is_load_op,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  reg_number,
  output logic [31:0] word_address,
  output logic        load_transfer,
  output logic        use_user_regs,
  output logic [1:0]  store_source,
  output logic [31:0] updated_base,
  output logic        base_update,
  output logic        flush_fetch,
  output logic        last_transfer
);

  btas_pkg::addr_op_t             aop;
  logic                           emit_load;
  btas_pkg::emit_t                emit;
  logic [btas_pkg::AddrWidth-1:0] newbase;
  logic [btas_pkg::AddrWidth-1:0] addr;

  btas_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .base_index        (base_index),
    .register_list     (register_list),
    .user_bank_request (user_bank_request),
    .write_back        (write_back),
    .is_load_op        (is_load_op),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .aop               (aop),
    .emit_load         (emit_load),
    .emit              (emit)
  );

  btas_addr_unit u_addr (
    .clk           (clk),
    .aop           (aop),
    .base_value    (base_value),
    .register_list (register_list),
    .pre_index     (pre_index),
    .count_up      (count_up),
    .newbase       (newbase),
    .addr          (addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      reg_number    <= emit.reg_number;
      word_address  <= addr;
      load_transfer <= emit.load_transfer;
      use_user_regs <= emit.use_user_regs;
      store_source  <= emit.store_source;
      updated_base  <= newbase;
      base_update   <= emit.base_update;
      flush_fetch   <= emit.flush_fetch;
      last_transfer <= emit.last_transfer;
    end
  end

  `BTAS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `BTAS_ASSERT_NOW(a_busy_mid_item, out_valid && !last_transfer, in_stall)
  `BTAS_ASSERT_NEXT(a_no_gap_in_item, out_valid && !out_stall && !last_transfer, out_valid)
  `BTAS_ASSERT_NEXT(a_addr_step, out_valid && !out_stall && !last_transfer, word_address == $past(word_address) + 32'd4)

endmodule

### sim/tb_block_transfer_address_sequencer.sv
// Self-checking testbench for block_transfer_address_sequencer: a behavioural
// predictor works out every transfer, and each result is checked against it in order.
// Depends on btas_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_block_transfer_address_sequencer;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 9;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int TAIL_CYCLES     = 24;
  localparam int HOLD_CYCLES     = 90;
  localparam int WATCHDOG_CYCLES = 400000;

  localparam logic [31:0] EMPTY_SPAN      = 32'h0000_0040;
  localparam logic [31:0] EMPTY_DA_OFFSET = 32'h0000_003C;
  localparam logic [15:0] FULL_LIST       = 16'hFFFF;

  typedef struct {
    logic [3:0]           reg_number;
    logic [31:0]          word_address;
    logic                 load_transfer;
    logic                 use_user_regs;
    btas_pkg::store_src_t store_source;
    logic [31:0]          updated_base;
    logic                 base_update;
    logic                 flush_fetch;
    logic                 last_transfer;
  } transfer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] base_value = '0;
  logic [3:0]  base_index = '0;
  logic [15:0] register_list = '0;
  logic        pre_index = 1'b0;
  logic        count_up = 1'b0;
  logic        user_bank_request = 1'b0;
  logic        write_back = 1'b0;
  logic        is_load_op = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  reg_number;
  logic [31:0] word_address;
  logic        load_transfer;
  logic        use_user_regs;
  logic [1:0]  store_source;
  logic [31:0] updated_base;
  logic        base_update;
  logic        flush_fetch;
  logic        last_transfer;

  transfer_t pending_transfers[$];
  int error_count    = 0;
  int issued_count   = 0;
  int checked_count  = 0;
  int empty_count    = 0;
  int stall_pct      = 0;
  int stall_run      = 0;
  int hold_left      = 0;
  bit hold_request   = 1'b0;
  bit sender_gaps    = 1'b0;
  int burst_left     = 0;

  block_transfer_address_sequencer DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .base_value(base_value),
    .base_index(base_index),
    .register_list(register_list),
    .pre_index(pre_index),
    .count_up(count_up),
    .user_bank_request(user_bank_request),
    .write_back(write_back),
    .is_load_op(is_load_op),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .reg_number(reg_number),
    .word_address(word_address),
    .load_transfer(load_transfer),
    .use_user_regs(use_user_regs),
    .store_source(store_source),
    .updated_base(updated_base),
    .base_update(base_update),
    .flush_fetch(flush_fetch),
    .last_transfer(last_transfer)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    #(WATCHDOG_CYCLES * 2 * HALF_PERIOD);
    $display("ERROR: watchdog expired with %0d transfers outstanding",
             pending_transfers.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Expands one instruction into its transfers.
  task automatic predict_transfers(input logic [31:0] base, input logic [3:0] bidx,
                                   input logic [15:0] list, input logic p, input logic u,
                                   input logic s, input logic w, input logic l);
    transfer_t   t;
    int          count;
    int          done;
    int          i;
    logic [31:0] span;
    logic [31:0] newbase;
    logic [31:0] addr;
    logic        pre;
    logic        upd;
    logic        usr;
    logic        seen;
    count = $countones(list);
    usr = s && !list[btas_pkg::PC_REG];
    if (count == 0) begin
      t.reg_number    = btas_pkg::PC_REG;
      t.word_address  = u ? base + (p ? btas_pkg::WORD_STEP : 32'h0)
                          : base - (p ? EMPTY_SPAN : EMPTY_DA_OFFSET);
      t.load_transfer = l;
      t.use_user_regs = usr;
      if (l) t.store_source = btas_pkg::SRC_REG;
      else t.store_source = btas_pkg::SRC_PLUS4;
      t.updated_base  = u ? base + EMPTY_SPAN : base - EMPTY_SPAN;
      t.base_update   = 1'b1;
      t.flush_fetch   = l;
      t.last_transfer = 1'b1;
      pending_transfers.push_back(t);
      empty_count++;
    end else begin
      span    = 32'(count) * btas_pkg::WORD_STEP;
      newbase = u ? base + span : base - span;
      addr    = u ? base : base - span;
      pre     = u ? p : !p;
      upd     = w && (!l || !list[bidx]);
      seen    = 1'b0;
      done    = 0;
      for (i = 0; i < 16; i++) begin
        if (list[i]) begin
          if (pre) addr = addr + btas_pkg::WORD_STEP;
          t.word_address = addr;
          if (!pre) addr = addr + btas_pkg::WORD_STEP;
          t.reg_number = 4'(i);
          if (l) t.store_source = btas_pkg::SRC_REG;
          else if (4'(i) == bidx && seen) t.store_source = btas_pkg::SRC_BASE;
          else if (4'(i) == btas_pkg::PC_REG) t.store_source = btas_pkg::SRC_PLUS4;
          else t.store_source = btas_pkg::SRC_REG;
          done++;
          t.load_transfer = l;
          t.use_user_regs = usr;
          t.updated_base  = newbase;
          t.last_transfer = (done == count);
          t.base_update   = (done == count) ? upd : 1'b0;
          t.flush_fetch   = l && (4'(i) == btas_pkg::PC_REG);
          pending_transfers.push_back(t);
          seen = 1'b1;
        end
      end
    end
  endtask

  // Prediction on accepted items, checking on accepted results.
  always @(posedge clk) begin
    transfer_t want;
    if (!rst && in_valid && !in_stall) begin
      predict_transfers(base_value, base_index, register_list, pre_index, count_up,
                        user_bank_request, write_back, is_load_op);
    end
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_transfers.size() == 0) begin
        $display("ERROR %0t: unexpected transfer of r%0d at %0h", $time, reg_number,
                 word_address);
        error_count++;
      end else begin
        want = pending_transfers.pop_front();
        checked_count++;
        if (reg_number !== want.reg_number)
          report_mismatch("reg_number", 32'(reg_number), 32'(want.reg_number));
        if (word_address !== want.word_address)
          report_mismatch("word_address", word_address, want.word_address);
        if (load_transfer !== want.load_transfer)
          report_mismatch("load_transfer", 32'(load_transfer), 32'(want.load_transfer));
        if (use_user_regs !== want.use_user_regs)
          report_mismatch("use_user_regs", 32'(use_user_regs), 32'(want.use_user_regs));
        if (store_source !== want.store_source)
          report_mismatch("store_source", 32'(store_source), 32'(want.store_source));
        if (updated_base !== want.updated_base)
          report_mismatch("updated_base", updated_base, want.updated_base);
        if (base_update !== want.base_update)
          report_mismatch("base_update", 32'(base_update), 32'(want.base_update));
        if (flush_fetch !== want.flush_fetch)
          report_mismatch("flush_fetch", 32'(flush_fetch), 32'(want.flush_fetch));
        if (last_transfer !== want.last_transfer)
          report_mismatch("last_transfer", 32'(last_transfer), 32'(want.last_transfer));
      end
    end
  end

  // Receiver: long hold-off on request, otherwise short random stall runs.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_pct == 0) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_run = $urandom_range(3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_instruction(input logic [31:0] base, input logic [3:0] bidx,
                                  input logic [15:0] list, input logic p, input logic u,
                                  input logic s, input logic w, input logic l);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 10);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    base_value        <= base;
    base_index        <= bidx;
    register_list     <= list;
    pre_index         <= p;
    count_up          <= u;
    user_bank_request <= s;
    write_back        <= w;
    is_load_op        <= l;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    issued_count++;
  endtask

  task automatic send_random_instruction();
    logic [31:0] base;
    logic [3:0]  bidx;
    logic [15:0] list;
    case ($urandom_range(9))
      0: base = 32'h0;
      1: base = 32'hFFFF_FFFF;
      2: base = $urandom_range(63);
      3: base = 32'hFFFF_FFFF - $urandom_range(63);
      default: base = $urandom;
    endcase
    bidx = 4'($urandom_range(15));
    case ($urandom_range(9))
      0: list = 16'h0;
      1: list = FULL_LIST;
      2, 3: list = 16'($urandom);
      4: list = (16'h1 << bidx) | (16'h1 << $urandom_range(15)) | 16'h8000;
      default: list = (16'h1 << $urandom_range(15)) | (16'h1 << $urandom_range(15))
                      | ($urandom_range(1) ? (16'h1 << bidx) : 16'h0);
    endcase
    send_instruction(base, bidx, list, 1'($urandom), 1'($urandom), 1'($urandom),
                     1'($urandom), 1'($urandom));
  endtask

  task automatic wait_for_drain();
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_transfers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_transfers.size() != 0) begin
      $display("ERROR %0t: timed out with %0d transfers outstanding", $time,
               pending_transfers.size());
      error_count++;
      pending_transfers.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Empty lists in all modes, wrap, base and PC stores, writeback and user bank rules.
  task automatic test_directed();
    sender_gaps = 1'b0;
    stall_pct   = 0;
    send_instruction(32'h0000_1000, 4'd3, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_instruction(32'h0000_1000, 4'd3, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
    send_instruction(32'h0000_0010, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    send_instruction(32'h0000_0020, 4'd15, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
    send_instruction(32'hFFFF_FFFC, 4'd0, FULL_LIST, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_instruction(32'hFFFF_FFF0, 4'd7, FULL_LIST, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_instruction(32'h0000_0000, 4'd15, FULL_LIST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    send_instruction(32'h0000_0008, 4'd1, FULL_LIST, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
    send_instruction(32'hFFFF_FFFF, 4'd0, 16'h0001, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
    send_instruction(32'h8000_0000, 4'd2, 16'h8000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
    send_instruction(32'h8000_0000, 4'd2, 16'h8000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    send_instruction(32'h0000_4000, 4'd4, 16'h8010, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    send_instruction(32'h0000_2000, 4'd5, 16'h0021, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_instruction(32'h0000_2000, 4'd0, 16'h0021, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_instruction(32'h0000_3000, 4'd9, 16'h0201, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
    send_instruction(32'h0000_3000, 4'd9, 16'h0101, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    send_instruction(32'h0000_3000, 4'd9, 16'h0101, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
    send_instruction(32'h1234_5678, 4'd6, 16'h7FFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_instruction(32'h0000_0004, 4'd15, 16'hC000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    send_instruction(32'hAAAA_5555, 4'd10, 16'hAAAA, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
    send_instruction(32'h5555_AAAA, 4'd13, 16'h5555, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    sender_gaps = 1'b1;
    stall_pct   = 30;
    repeat (200) send_random_instruction();
    wait_for_drain();
  endtask

  // Receiver holds off while the sender keeps offering items back to back.
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    stall_pct   = 0;
    @(posedge clk);
    hold_request = 1'b1;
    repeat (20) send_random_instruction();
    wait_for_drain();
  endtask

  task automatic test_full_rate();
    sender_gaps = 1'b0;
    stall_pct   = 0;
    repeat (60) send_random_instruction();
    wait_for_drain();
  endtask

  task automatic test_heavy_stall();
    sender_gaps = 1'b1;
    stall_pct   = 75;
    repeat (40) send_random_instruction();
    wait_for_drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic();
    test_backpressure();
    test_full_rate();
    test_heavy_stall();
    $display("Summary: %0d instructions (%0d with empty lists) produced %0d checked transfers,",
             issued_count, empty_count, checked_count);
    $display("  under sender gaps, random and long output stalls, and full-rate streams.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/btas_pkg.sv
design/btas_addr_unit.sv
design/btas_seq.sv
design/block_transfer_address_sequencer.sv
sim/tb_block_transfer_address_sequencer.sv
